// ===== hw/rtl/crp_tsh_pkg.sv =====
// Package for the table-size histogram restaurant block.
// Holds shared constants, operation codes, the sequencer control word and its program.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crp_tsh_pkg;

  localparam int unsigned CRP_MAX_TABLE_SIZE = 256;
  localparam int unsigned CRP_MAX_CUSTOMERS  = 65535;

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned SIZE_W = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] OP_SEAT   = 2'd0;
  localparam logic [1:0] OP_OPEN   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FIRST,
    ST_MUL,
    ST_SUB,
    ST_HIT,
    ST_SEAT,
    ST_SEAT_MV,
    ST_SEAT_UP,
    ST_RM,
    ST_RM_MV,
    ST_RM_DN,
    ST_RM1,
    ST_OPEN,
    ST_ERR,
    ST_DONE
  } step_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_NO_REQ,
    C_PRE_ERR,
    C_OP_OPEN,
    C_OVER,
    C_FOUND,
    C_OP_REMOVE,
    C_S_AT_MAX,
    C_RD_FULL,
    C_S_IS_ONE,
    C_OUT_FULL
  } cond_e;

  typedef enum logic [1:0] {
    A_S_M1,
    A_S,
    A_S_M2
  } addr_sel_e;

  typedef enum logic {
    W_CNT_DEC,
    W_RD_INC
  } wsrc_e;

  typedef enum logic [1:0] {
    K_KEEP,
    K_INC,
    K_DEC
  } tally_e;

  typedef enum logic [1:0] {
    Z_S,
    Z_S_INC,
    Z_S_DEC
  } size_sel_e;

  // One program step. All actions but rd and mul fire only when the jump is not taken.
  typedef struct packed {
    cond_e     cond;
    step_e     jump;
    step_e     nxt;
    logic      load;
    logic      rd;
    addr_sel_e rd_addr;
    logic      mul;
    logic      sub;
    logic      inc_s;
    logic      wr;
    addr_sel_e wr_addr;
    wsrc_e     wsrc;
    tally_e    cust;
    tally_e    tab;
    logic      res;
    size_sel_e size;
    logic      res_err;
    logic      emit;
  } ctrl_t;

  function automatic ctrl_t crp_ucode(step_e pc);
    ctrl_t c;
    c = ctrl_t'('0);
    c.cond = C_NEVER;
    c.jump = ST_IDLE;
    c.nxt  = ST_IDLE;
    unique case (pc)
      ST_IDLE: begin
        c.load = 1'b1;
        c.cond = C_NO_REQ;
        c.jump = ST_IDLE;
        c.nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        c.cond = C_PRE_ERR;
        c.jump = ST_ERR;
        c.nxt  = ST_FIRST;
      end
      ST_FIRST: begin
        c.rd      = 1'b1;
        c.rd_addr = A_S_M1;
        c.cond    = C_OP_OPEN;
        c.jump    = ST_OPEN;
        c.nxt     = ST_MUL;
      end
      ST_MUL: begin
        c.mul  = 1'b1;
        c.cond = C_OVER;
        c.jump = ST_ERR;
        c.nxt  = ST_SUB;
      end
      ST_SUB: begin
        c.sub     = 1'b1;
        c.inc_s   = 1'b1;
        c.rd      = 1'b1;
        c.rd_addr = A_S;
        c.cond    = C_FOUND;
        c.jump    = ST_HIT;
        c.nxt     = ST_MUL;
      end
      ST_HIT: begin
        c.cond = C_OP_REMOVE;
        c.jump = ST_RM;
        c.nxt  = ST_SEAT;
      end
      ST_SEAT: begin
        c.rd      = 1'b1;
        c.rd_addr = A_S;
        c.cond    = C_S_AT_MAX;
        c.jump    = ST_ERR;
        c.nxt     = ST_SEAT_MV;
      end
      ST_SEAT_MV: begin
        c.wr      = 1'b1;
        c.wr_addr = A_S_M1;
        c.wsrc    = W_CNT_DEC;
        c.cond    = C_RD_FULL;
        c.jump    = ST_ERR;
        c.nxt     = ST_SEAT_UP;
      end
      ST_SEAT_UP: begin
        c.wr      = 1'b1;
        c.wr_addr = A_S;
        c.wsrc    = W_RD_INC;
        c.cust    = K_INC;
        c.res     = 1'b1;
        c.size    = Z_S_INC;
        c.nxt     = ST_DONE;
      end
      ST_RM: begin
        c.rd      = 1'b1;
        c.rd_addr = A_S_M2;
        c.cond    = C_S_IS_ONE;
        c.jump    = ST_RM1;
        c.nxt     = ST_RM_MV;
      end
      ST_RM_MV: begin
        c.wr      = 1'b1;
        c.wr_addr = A_S_M1;
        c.wsrc    = W_CNT_DEC;
        c.cond    = C_RD_FULL;
        c.jump    = ST_ERR;
        c.nxt     = ST_RM_DN;
      end
      ST_RM_DN: begin
        c.wr      = 1'b1;
        c.wr_addr = A_S_M2;
        c.wsrc    = W_RD_INC;
        c.cust    = K_DEC;
        c.res     = 1'b1;
        c.size    = Z_S_DEC;
        c.nxt     = ST_DONE;
      end
      ST_RM1: begin
        c.wr      = 1'b1;
        c.wr_addr = A_S_M1;
        c.wsrc    = W_CNT_DEC;
        c.cust    = K_DEC;
        c.tab     = K_DEC;
        c.res     = 1'b1;
        c.size    = Z_S_DEC;
        c.nxt     = ST_DONE;
      end
      ST_OPEN: begin
        c.wr      = 1'b1;
        c.wr_addr = A_S_M1;
        c.wsrc    = W_RD_INC;
        c.cust    = K_INC;
        c.tab     = K_INC;
        c.res     = 1'b1;
        c.size    = Z_S;
        c.cond    = C_RD_FULL;
        c.jump    = ST_ERR;
        c.nxt     = ST_DONE;
      end
      ST_ERR: begin
        c.res_err = 1'b1;
        c.nxt     = ST_DONE;
      end
      ST_DONE: begin
        c.emit = 1'b1;
        c.cond = C_OUT_FULL;
        c.jump = ST_DONE;
        c.nxt  = ST_IDLE;
      end
      default: begin
        c.nxt = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crp_table_size_histogram.sv =====
// A seating, opening or removal request is accepted while the block is idle and then runs a
// short microprogram: opening a table reads one histogram entry and writes it back, while
// seating or removal walks the histogram one table size at a time (a multiply, then a
// subtract together with the read for the next size) up to the chosen size, then moves the
// table and delivers the result; a request that is refused or finds no fitting table size
// delivers an error result instead. After reset the block clears the histogram and takes
// no request until then; discount writes are taken at any time.
// Depends on crp_tsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crp_table_size_histogram #(
  parameter int unsigned MAX_TABLE_SIZE = crp_tsh_pkg::CRP_MAX_TABLE_SIZE,
  parameter int unsigned MAX_CUSTOMERS  = crp_tsh_pkg::CRP_MAX_CUSTOMERS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [15:0]                      cfg_discount_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [31:0]                      draw_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [crp_tsh_pkg::SIZE_W-1:0]        table_size_o,
  output logic [crp_tsh_pkg::CNT_W-1:0]         customers_o,
  output logic [crp_tsh_pkg::CNT_W-1:0]         tables_o,
  output logic                                  error_o
);

  import crp_tsh_pkg::*;

  localparam int unsigned AW = (MAX_TABLE_SIZE > 1) ? $clog2(MAX_TABLE_SIZE) : 1;
  localparam int unsigned SW = $clog2(MAX_TABLE_SIZE + 2);
  localparam int unsigned WW = SW + 16;
  localparam int unsigned PW = WW + CNT_W;
  localparam int unsigned RW = PW + 1;
  localparam logic [SW-1:0] S_MAX   = SW'(MAX_TABLE_SIZE);
  localparam logic [AW-1:0] CLR_END = AW'(MAX_TABLE_SIZE - 1);

  logic [CNT_W-1:0] hist_q [MAX_TABLE_SIZE];
  logic [CNT_W-1:0] rd_data_q;

  step_e            pc_q, pc_d;
  ctrl_t            ctrl;
  logic             take, fire;
  logic             clr_q;
  logic [AW-1:0]    clr_idx_q;
  logic [15:0]      discount_q;
  logic [1:0]       op_q;
  logic [SW-1:0]    s_q;
  logic [RW-1:0]    r_q, r_diff;
  logic [PW-1:0]    prod_q, prod_d;
  logic [WW-1:0]    weight;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cust_q, tab_q;
  logic [SIZE_W-1:0] res_size_q;
  logic             res_err_q;
  logic [SW-1:0]    size_full;
  logic             out_valid_q;
  logic             out_full;
  logic             cust_full;
  logic             pre_err;
  logic             found;
  logic             accept;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [SIZE_W-1:0] table_size_q;
  logic [CNT_W-1:0] customers_q, tables_q;
  logic             error_q;

  function automatic logic [AW-1:0] pick_addr(addr_sel_e sel, logic [SW-1:0] s);
    logic [SW-1:0] a;
    unique case (sel)
      A_S_M1:  a = s - SW'(1);
      A_S:     a = s;
      A_S_M2:  a = s - SW'(2);
      default: a = s;
    endcase
    return (a < S_MAX) ? a[AW-1:0] : '0;
  endfunction

  assign ctrl = crp_ucode(pc_q);

  assign out_full  = out_valid_q && out_stall_i;
  assign cust_full = ({16'b0, cust_q} >= 32'(MAX_CUSTOMERS)) || (cust_q == CNT_MAX);
  assign weight    = (op_q == OP_REMOVE) ? WW'(s_q) : ({s_q, 16'b0} - WW'(discount_q));
  assign prod_d    = PW'(rd_data_q) * PW'(weight);
  assign r_diff    = r_q - RW'(prod_q);
  assign found     = (cnt_q != '0) && (r_diff[RW-1] || (r_diff == '0));

  always_comb begin
    unique case (op_q)
      OP_SEAT:   pre_err = cust_full;
      OP_OPEN:   pre_err = cust_full || (tab_q == CNT_MAX);
      OP_REMOVE: pre_err = (cust_q == '0);
      default:   pre_err = 1'b1;
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:     take = 1'b0;
      C_NO_REQ:    take = !accept;
      C_PRE_ERR:   take = pre_err;
      C_OP_OPEN:   take = (op_q == OP_OPEN);
      C_OVER:      take = (s_q > S_MAX);
      C_FOUND:     take = found;
      C_OP_REMOVE: take = (op_q == OP_REMOVE);
      C_S_AT_MAX:  take = (s_q >= S_MAX);
      C_RD_FULL:   take = (rd_data_q == CNT_MAX);
      C_S_IS_ONE:  take = (s_q == SW'(1));
      C_OUT_FULL:  take = out_full;
      default:     take = 1'b0;
    endcase
    fire = !take;
    pc_d = take ? ctrl.jump : ctrl.nxt;
  end

  always_comb begin
    in_stall_o  = clr_q || (pc_q != ST_IDLE);
    accept      = in_valid_i && !in_stall_o;
    cfg_ready_o = 1'b1;
    mem_raddr   = pick_addr(ctrl.rd_addr, s_q);
    if (clr_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else begin
      mem_we    = ctrl.wr && fire;
      mem_waddr = pick_addr(ctrl.wr_addr, s_q);
      mem_wdata = (ctrl.wsrc == W_RD_INC) ? (rd_data_q + CNT_W'(1)) : (cnt_q - CNT_W'(1));
    end
    unique case (ctrl.size)
      Z_S:     size_full = s_q;
      Z_S_INC: size_full = s_q + SW'(1);
      Z_S_DEC: size_full = s_q - SW'(1);
      default: size_full = s_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_q[mem_waddr] <= mem_wdata;
    end
    if (ctrl.rd) begin
      rd_data_q <= hist_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_IDLE;
      clr_q       <= 1'b1;
      clr_idx_q   <= '0;
      discount_q  <= '0;
      cust_q      <= '0;
      tab_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + AW'(1);
        if (clr_idx_q == CLR_END) begin
          clr_q <= 1'b0;
        end
      end
      if (cfg_valid_i) begin
        discount_q <= cfg_discount_i;
      end
      if (fire) begin
        unique case (ctrl.cust)
          K_INC:   cust_q <= cust_q + CNT_W'(1);
          K_DEC:   cust_q <= cust_q - CNT_W'(1);
          default: cust_q <= cust_q;
        endcase
        unique case (ctrl.tab)
          K_INC:   tab_q <= tab_q + CNT_W'(1);
          K_DEC:   tab_q <= (tab_q != '0) ? (tab_q - CNT_W'(1)) : tab_q;
          default: tab_q <= tab_q;
        endcase
      end
      if (ctrl.emit && fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load && fire) begin
      op_q <= operation_i;
      s_q  <= SW'(1);
      r_q  <= (operation_i == OP_REMOVE) ? RW'(draw_i[31:16]) : RW'(draw_i);
    end else begin
      if (ctrl.sub && fire) begin
        r_q <= r_diff;
      end
      if (ctrl.inc_s && fire) begin
        s_q <= s_q + SW'(1);
      end
    end
    if (ctrl.mul) begin
      prod_q <= prod_d;
      cnt_q  <= rd_data_q;
    end
    if (ctrl.res && fire) begin
      res_size_q <= SIZE_W'(size_full);
      res_err_q  <= 1'b0;
    end else if (ctrl.res_err && fire) begin
      res_size_q <= '0;
      res_err_q  <= 1'b1;
    end
    if (ctrl.emit && fire) begin
      table_size_q <= res_size_q;
      customers_q  <= cust_q;
      tables_q     <= tab_q;
      error_q      <= res_err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign table_size_o = table_size_q;
  assign customers_o  = customers_q;
  assign tables_o     = tables_q;
  assign error_o      = error_q;

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_SUB) |-> (s_q <= S_MAX))
    else $error("Walk went past the largest table size.");

  a_emit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_DONE && !out_full) |=> (out_valid_q && pc_q == ST_IDLE))
    else $error("Finished request did not produce a result.");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !clr_q) |-> (pc_q != ST_IDLE && pc_q != ST_DONE))
    else $error("Histogram written outside of a request.");

  a_error_keeps_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_ERR) |=> ($stable(cust_q) && $stable(tab_q)))
    else $error("Refused request changed the totals.");

endmodule

`default_nettype wire
